// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its antecedent
`define TCPOKS_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// property holds in the cycle after its antecedent
`define TCPOKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcpoks_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// TCP option kind search package
// Sizes, parse phases and the beat and result types.
// ---------------------------------------------------------------------------
package tcpoks_pkg;

	localparam int MAX_OPTIONS    = 40;
	localparam int MAX_AREA_BYTES = 64;

	localparam int OFF_W = $clog2(MAX_AREA_BYTES + 1);
	localparam int CNT_W = $clog2(MAX_OPTIONS + 1);
	localparam int TOT_W = 16;

	typedef enum logic [1:0] {
		PH_KIND,
		PH_LEN,
		PH_SKIP,
		PH_CLOSED
	} phase_t;

	typedef struct packed {
		logic limit;
		logic zero;
		logic over;
		logic found;
	} flags_t;

	typedef struct packed {
		logic [7:0] opt_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] wanted_kind;
	} beat_t;

	typedef struct packed {
		logic [TOT_W-1:0] too_many_total;
		logic [TOT_W-1:0] zero_length_total;
		logic [TOT_W-1:0] overrun_total;
		logic             too_many_options;
		logic             zero_length;
		logic             size_overrun;
		logic             found;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/tcpoks_walk.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// TCP option walker
// Per-area parse state, option count, flags and saturating totals.
// ---------------------------------------------------------------------------
module tcpoks_walk import tcpoks_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire beat_t   beat,
	output logic         res_valid,
	output result_t      res
);

	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(MAX_AREA_BYTES - 1);
	localparam logic [OFF_W-1:0] OFF_TOP  = OFF_W'(MAX_AREA_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_OPTIONS);

	phase_t             phase_q, phase_d, ph_c;
	logic [OFF_W-1:0]   off_q, off_d, off_c;
	logic [7:0]         skip_q, skip_d, skip_c;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_c;
	logic [7:0]         kind_q, kind_d, kind_c;
	logic               stop_q, stop_d, stop_c;
	flags_t             flags_q, flags_d, flags_c;
	logic [TOT_W-1:0]   over_tot_q, over_tot_d;
	logic [TOT_W-1:0]   zero_tot_q, zero_tot_d;
	logic [TOT_W-1:0]   lim_tot_q, lim_tot_d;

	// option start evaluation, shared by kind phase and length-of-one case
	logic [7:0]         tk_k;
	logic [CNT_W-1:0]   tk_cnt;
	flags_t             tk_flags;
	logic               tk_stop;
	phase_t             tk_ph;
	logic               at_end, active;

	always_comb begin
		// area restart on first byte
		if (beat.first_byte) begin
			ph_c    = PH_KIND;
			off_c   = '0;
			skip_c  = '0;
			cnt_c   = '0;
			kind_c  = beat.wanted_kind;
			stop_c  = 1'b0;
			flags_c = '0;
		end else begin
			ph_c    = phase_q;
			off_c   = off_q;
			skip_c  = skip_q;
			cnt_c   = cnt_q;
			kind_c  = kind_q;
			stop_c  = stop_q;
			flags_c = flags_q;
		end

		at_end = beat.last_byte || (off_c >= OFF_LAST);
		active = !(stop_c && ph_c == PH_KIND) && (off_c <= OFF_LAST);

		tk_k     = (ph_c == PH_KIND) ? beat.opt_byte : 8'd1;
		tk_cnt   = cnt_c + CNT_W'(1);
		tk_flags = flags_c;
		tk_stop  = stop_c;
		if (tk_k == kind_c) begin
			tk_flags.found = 1'b1;
			tk_stop        = 1'b1;
			tk_ph          = PH_KIND;
		end else begin
			if (tk_cnt >= CNT_MAX) begin
				tk_flags.limit = 1'b1;
				tk_stop        = 1'b1;
			end
			if (tk_k <= 8'd1) begin
				tk_ph = PH_KIND;
			end else if (at_end) begin
				tk_flags.over = 1'b1;
				tk_ph         = PH_KIND;
			end else begin
				tk_ph = PH_LEN;
			end
		end

		phase_d    = ph_c;
		off_d      = off_c;
		skip_d     = skip_c;
		cnt_d      = cnt_c;
		kind_d     = kind_c;
		stop_d     = stop_c;
		flags_d    = flags_c;
		over_tot_d = over_tot_q;
		zero_tot_d = zero_tot_q;
		lim_tot_d  = lim_tot_q;
		res_valid  = 1'b0;

		if (ph_c != PH_CLOSED) begin
			if (active) begin
				unique case (ph_c)
					PH_KIND: begin
						cnt_d   = tk_cnt;
						flags_d = tk_flags;
						stop_d  = tk_stop;
						phase_d = tk_ph;
					end
					PH_LEN: begin
						if (beat.opt_byte == 8'd0) begin
							flags_d.zero = 1'b1;
							stop_d       = 1'b1;
							phase_d      = PH_KIND;
						end else if (beat.opt_byte == 8'd1) begin
							phase_d = PH_KIND;
							if (!stop_c) begin
								cnt_d   = tk_cnt;
								flags_d = tk_flags;
								stop_d  = tk_stop;
								phase_d = tk_ph;
							end
						end else if (beat.opt_byte == 8'd2) begin
							phase_d = PH_KIND;
						end else if (at_end) begin
							flags_d.over = 1'b1;
							phase_d      = PH_KIND;
						end else begin
							skip_d  = beat.opt_byte - 8'd2;
							phase_d = PH_SKIP;
						end
					end
					PH_SKIP: begin
						skip_d = (skip_c != 8'd0) ? skip_c - 8'd1 : skip_c;
						if (skip_d == 8'd0) begin
							phase_d = PH_KIND;
						end else if (at_end) begin
							flags_d.over = 1'b1;
							skip_d       = '0;
							phase_d      = PH_KIND;
						end
					end
					default: begin
						phase_d = ph_c;
					end
				endcase
				if (at_end) begin
					stop_d  = 1'b1;
					phase_d = PH_KIND;
					skip_d  = '0;
				end
			end

			if (off_c < OFF_TOP) begin
				off_d = off_c + OFF_W'(1);
			end

			if (beat.last_byte) begin
				if (flags_d.over && over_tot_q != '1) begin
					over_tot_d = over_tot_q + TOT_W'(1);
				end
				if (flags_d.zero && zero_tot_q != '1) begin
					zero_tot_d = zero_tot_q + TOT_W'(1);
				end
				if (flags_d.limit && lim_tot_q != '1) begin
					lim_tot_d = lim_tot_q + TOT_W'(1);
				end
				res_valid = 1'b1;
				phase_d   = PH_CLOSED;
			end
		end

		res.found             = flags_d.found;
		res.size_overrun      = flags_d.over;
		res.zero_length       = flags_d.zero;
		res.too_many_options  = flags_d.limit;
		res.overrun_total     = over_tot_d;
		res.zero_length_total = zero_tot_d;
		res.too_many_total    = lim_tot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_KIND;
			off_q      <= '0;
			skip_q     <= '0;
			cnt_q      <= '0;
			kind_q     <= '0;
			stop_q     <= 1'b0;
			flags_q    <= '0;
			over_tot_q <= '0;
			zero_tot_q <= '0;
			lim_tot_q  <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			off_q      <= off_d;
			skip_q     <= skip_d;
			cnt_q      <= cnt_d;
			kind_q     <= kind_d;
			stop_q     <= stop_d;
			flags_q    <= flags_d;
			over_tot_q <= over_tot_d;
			zero_tot_q <= zero_tot_d;
			lim_tot_q  <= lim_tot_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tcp_option_kind_search.sv -----
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// TCP option kind search
// Walks a TCP options area one byte per beat and reports the wanted kind.
// ---------------------------------------------------------------------------
// One options byte per input beat, first byte flagged on tuser, final byte
// on tlast; wanted_kind is taken with the first byte. One result beat follows
// each last byte, carrying the found/overrun/zero-length/limit flags of that
// area and three saturating 16-bit totals. Throughput is one byte per cycle
// while no untaken result is held in the result register; a beat passes the
// input register, the combinational walker update and the result register. Beats after
// a last byte without a new first byte are consumed and give no result.
module tcp_option_kind_search import tcpoks_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // opt_byte[7:0], wanted_kind[15:8]
	input  wire logic        s_axis_tuser,   // first_byte
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata    // found, size_overrun, zero_length,
	                                          // too_many_options, overrun_total,
	                                          // zero_length_total, too_many_total,
	                                          // zero pad
);

	logic    v_s1;
	beat_t   beat_s1;
	logic    advance;
	logic    res_valid;
	result_t res;
	logic    m_valid_q;
	result_t m_data_q;

	assign advance       = v_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			beat_s1.opt_byte    <= s_axis_tdata[7:0];
			beat_s1.wanted_kind <= s_axis_tdata[15:8];
			beat_s1.first_byte  <= s_axis_tuser;
			beat_s1.last_byte   <= s_axis_tlast;
		end
	end

	tcpoks_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.beat      (beat_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'd0, m_data_q};

	`TCPOKS_ASSERT(a_res_on_last, clk, arst_n, advance && res_valid, beat_s1.last_byte, "result without last byte")
	`TCPOKS_ASSERT(a_ready_when_empty, clk, arst_n, !v_s1, s_axis_tready, "input register empty but not ready")
	`TCPOKS_ASSERT_NEXT(a_load_shows, clk, arst_n, advance && res_valid, m_axis_tvalid, "result not presented")

endmodule
`default_nettype wire

// ----- test/tcp_option_kind_search_tb.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// TCP option kind search testbench
// Streams options areas byte by byte through the walker and checks every
// result beat against an in-bench model of the kind/length walk. A short
// directed set covers the corner cases. Randomised areas follow: mostly
// well-formed option lists, with noise, long areas and broken framing mixed
// in. Both handshakes are throttled at random, and once the result side is
// held off long enough to back up the input.
// ---------------------------------------------------------------------------
module tcp_option_kind_search_tb;
	import tcpoks_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 900;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // opt_byte[7:0], wanted_kind[15:8]
	logic        s_axis_tuser = 1'b0; // first_byte
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // found, size_overrun, zero_length,
	                                  // too_many_options, overrun_total,
	                                  // zero_length_total, too_many_total, pad

	tcp_option_kind_search i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	beat_t       options_bytes[$];
	result_t     area_reports[$];
	int          total_beats = 0;
	int          bytes_in = 0;
	int          results_seen = 0;
	int          errors = 0;
	int unsigned cycles = 0;
	int          n_found = 0, n_over = 0, n_zero = 0, n_limit = 0;
	logic        calm;

	assign calm = (bytes_in + 150 >= total_beats);

	// walker model state
	phase_t      ph = PH_KIND;
	int unsigned offs = 0;
	int unsigned skip_left = 0;
	int unsigned n_opts = 0;
	logic [7:0]  want = '0;
	bit          stopped = 1'b0;
	flags_t      fl = '0;
	logic [15:0] over_total = '0, zero_total = '0, limit_total = '0;

	function automatic logic [15:0] sat16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void open_option(logic [7:0] k, bit at_end);
		n_opts++;
		if (k == want) begin
			fl.found = 1'b1;
			stopped = 1'b1;
			ph = PH_KIND;
			return;
		end
		if (n_opts >= MAX_OPTIONS) begin
			fl.limit = 1'b1;
			stopped = 1'b1;
		end
		if (k <= 8'd1) begin
			ph = PH_KIND;
		end else if (at_end) begin
			fl.over = 1'b1;
			ph = PH_KIND;
		end else begin
			ph = PH_LEN;
		end
	endfunction

	function automatic void walk_byte(beat_t b);
		bit      at_end;
		bit      active;
		result_t r;
		if (b.first_byte) begin
			ph = PH_KIND;
			offs = 0;
			skip_left = 0;
			n_opts = 0;
			want = b.wanted_kind;
			stopped = 1'b0;
			fl = '0;
		end
		if (ph == PH_CLOSED)
			return;
		at_end = b.last_byte || offs >= MAX_AREA_BYTES - 1;
		active = !(stopped && ph == PH_KIND) && offs <= MAX_AREA_BYTES - 1;
		if (active) begin
			case (ph)
				PH_KIND: open_option(b.opt_byte, at_end);
				PH_LEN: begin
					if (b.opt_byte == 8'd0) begin
						fl.zero = 1'b1;
						stopped = 1'b1;
						ph = PH_KIND;
					end else if (b.opt_byte == 8'd1) begin
						ph = PH_KIND;
						if (!stopped)
							open_option(8'd1, at_end);
					end else if (b.opt_byte == 8'd2) begin
						ph = PH_KIND;
					end else if (at_end) begin
						fl.over = 1'b1;
						ph = PH_KIND;
					end else begin
						skip_left = b.opt_byte - 2;
						ph = PH_SKIP;
					end
				end
				default: begin
					if (skip_left > 0)
						skip_left--;
					if (skip_left == 0) begin
						ph = PH_KIND;
					end else if (at_end) begin
						fl.over = 1'b1;
						skip_left = 0;
						ph = PH_KIND;
					end
				end
			endcase
			if (at_end) begin
				stopped = 1'b1;
				ph = PH_KIND;
				skip_left = 0;
			end
		end
		if (offs < MAX_AREA_BYTES)
			offs++;
		if (!b.last_byte)
			return;
		if (fl.over)
			over_total = sat16(over_total);
		if (fl.zero)
			zero_total = sat16(zero_total);
		if (fl.limit)
			limit_total = sat16(limit_total);
		r.found = fl.found;
		r.size_overrun = fl.over;
		r.zero_length = fl.zero;
		r.too_many_options = fl.limit;
		r.overrun_total = over_total;
		r.zero_length_total = zero_total;
		r.too_many_total = limit_total;
		area_reports.push_back(r);
		ph = PH_CLOSED;
	endfunction

	// stimulus helpers
	task automatic add_beat(input logic [7:0] b, input bit first, input bit last,
	                        input logic [7:0] kind_wanted);
		beat_t nb;
		nb.opt_byte = b;
		nb.first_byte = first;
		nb.last_byte = last;
		nb.wanted_kind = first ? kind_wanted : 8'($urandom);
		options_bytes.push_back(nb);
	endtask

	task automatic add_area(input logic [7:0] bytes[$], input logic [7:0] kind_wanted);
		for (int i = 0; i < bytes.size(); i++)
			add_beat(bytes[i], i == 0, i == bytes.size() - 1, kind_wanted);
	endtask

	function automatic void fill_options(ref logic [7:0] bytes[$], ref logic [7:0] kinds[$],
	                                     input int n);
		logic [7:0] k;
		int         len;
		int         r;
		while (bytes.size() < n) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				k = 8'd0;
			else if (r <= 3)
				k = 8'd1;
			else
				k = 8'($urandom_range(2, 255));
			bytes.push_back(k);
			kinds.push_back(k);
			if (k >= 8'd2) begin
				len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
				bytes.push_back(8'(len));
				for (int j = 2; j < len; j++)
					bytes.push_back(8'($urandom));
			end
		end
		while (bytes.size() > n)
			void'(bytes.pop_back());
	endfunction

	// sender
	beat_t next_beat;
	int    gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				gap_left <= $urandom_range(0, 15);
				s_axis_tvalid <= 1'b0;
			end else if (options_bytes.size() != 0) begin
				next_beat = options_bytes.pop_front();
				s_axis_tdata <= {next_beat.wanted_kind, next_beat.opt_byte};
				s_axis_tuser <= next_beat.first_byte;
				s_axis_tlast <= next_beat.last_byte;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	int stall_left = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			held_once <= 1'b0;
		end else if (!held_once && bytes_in >= 300) begin
			held_once <= 1'b1;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= (hold_left == 1);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// input beats feed the model
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			walk_byte({s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast, s_axis_tdata[15:8]});
			bytes_in <= bytes_in + 1;
		end
	end

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// result beats against the model
	result_t got, exp_r;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[51:0]);
			results_seen++;
			n_found += got.found;
			n_over += got.size_overrun;
			n_zero += got.zero_length;
			n_limit += got.too_many_options;
			if (area_reports.size() == 0) begin
				$error("result beat with no area report pending");
				errors++;
			end else begin
				exp_r = area_reports.pop_front();
				check_field("found", exp_r.found, got.found);
				check_field("size_overrun", exp_r.size_overrun, got.size_overrun);
				check_field("zero_length", exp_r.zero_length, got.zero_length);
				check_field("too_many_options", exp_r.too_many_options, got.too_many_options);
				check_field("overrun_total", exp_r.overrun_total, got.overrun_total);
				check_field("zero_length_total", exp_r.zero_length_total, got.zero_length_total);
				check_field("too_many_total", exp_r.too_many_total, got.too_many_total);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	logic [7:0] area[$];
	logic [7:0] kinds[$];
	logic [7:0] kw;
	int         shape;
	int         n_areas;
	int         n_directed;

	initial begin
		// no first byte after reset: walk starts with wanted kind 0
		add_beat(8'd1, 1'b0, 1'b0, 8'd0);
		add_beat(8'd0, 1'b0, 1'b1, 8'd0);
		// stray byte after the area end, marked last
		add_beat(8'h55, 1'b0, 1'b1, 8'd0);
		// one-byte area, kind with a length byte beyond the end
		add_area('{8'd2}, 8'd5);
		add_area('{8'd1}, 8'd0);
		// zero length
		add_area('{8'd3, 8'd0, 8'd1, 8'd7}, 8'd9);
		// length of one acts as a NOP kind
		add_area('{8'd2, 8'd1, 8'd8}, 8'd1);
		// length two on the last byte: clean end
		add_area('{8'd4, 8'd2}, 8'd7);
		// match stops the walk, trailing zero ignored
		add_area('{8'd1, 8'd8, 8'd0}, 8'd8);
		// extremes
		add_area('{8'd255, 8'd255, 8'd0}, 8'd0);
		add_area('{8'd1, 8'd255}, 8'd255);
		n_directed = options_bytes.size();

		n_areas = 0;
		while (options_bytes.size() < n_directed + RANDOM_BYTES) begin
			shape = $urandom_range(0, 9);
			if (n_areas == 2 || n_areas == 11)
				shape = 7;
			if (n_areas == 5)
				shape = 8;
			area.delete();
			kinds.delete();
			kw = 8'($urandom);
			case (shape)
				6: begin
					repeat ($urandom_range(1, 40))
						area.push_back(($urandom_range(0, 3) == 0) ?
							8'($urandom_range(0, 2)) : 8'($urandom));
					add_area(area, kw);
				end
				7: begin
					// option limit: 39 options, then one more that may overrun
					kw = 8'($urandom_range(100, 255));
					repeat (MAX_OPTIONS - 1) begin
						if ($urandom_range(0, 1) == 0) begin
							area.push_back(8'd1);
						end else begin
							area.push_back(8'd4);
							area.push_back(8'd2);
						end
					end
					area.push_back(8'($urandom_range(2, 99)));
					area.push_back(8'($urandom_range(0, 12)));
					repeat ($urandom_range(0, 12))
						area.push_back(8'($urandom));
					add_area(area, kw);
				end
				8: begin
					fill_options(area, kinds, $urandom_range(60, 72));
					add_area(area, kw);
				end
				9: begin
					fill_options(area, kinds, $urandom_range(2, 20));
					if ($urandom_range(0, 1) == 0) begin
						for (int i = 0; i < area.size(); i++)
							add_beat(area[i], i == 0, 1'b0, kw);
					end else begin
						add_area(area, kw);
						repeat ($urandom_range(1, 4))
							add_beat(8'($urandom), 1'b0, $urandom_range(0, 1), kw);
					end
				end
				default: begin
					fill_options(area, kinds,
						$urandom_range(1, ($urandom_range(0, 7) == 0) ? 64 : 40));
					if (kinds.size() != 0 && $urandom_range(0, 1) == 0)
						kw = kinds[$urandom_range(0, kinds.size() - 1)];
					add_area(area, kw);
				end
			endcase
			n_areas++;
		end
		total_beats = options_bytes.size();

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_in != total_beats)
			@(posedge clk);
		while (area_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Walked %0d option bytes (%0d random areas), %0d area results checked",
			bytes_in, n_areas, results_seen);
		$display("Flags seen: found %0d, overrun %0d, zero length %0d, option limit %0d",
			n_found, n_over, n_zero, n_limit);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/tcpoks_pkg.sv
rtl/tcpoks_walk.sv
rtl/tcp_option_kind_search.sv
test/tcp_option_kind_search_tb.sv
